// ===== hw/rtl/drp_pkg.sv =====
package drp_pkg;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_BYTE       = 2'd0,
        KIND_FIELD_END  = 2'd1,
        KIND_RECORD_END = 2'd2
    } kind_t;

    // Input commands
    localparam logic CMD_TEXT = 1'b0;
    localparam logic CMD_END  = 1'b1;

    // Configuration register indexes
    localparam int CFG_INDEX_BITS = 4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DELIMITER  = 4'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_HAS_HEADER = 4'd1;
    localparam int CFG_DATA_BITS = 8;

    // Reset values of the configuration registers
    localparam logic [7:0] DELIMITER_RESET  = 8'h2C;
    localparam logic       HAS_HEADER_RESET = 1'b1;

    // Special bytes
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    typedef struct packed {
        logic       command;
        logic [7:0] char_in;
    } in_item_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  char_out;
        logic [31:0] record_line;
        logic [10:0] record_fields;
        logic        unterminated;
        logic        width_mismatch;
        logic        header_record;
        logic [10:0] expected_fields;
        logic [31:0] data_rows;
        logic [31:0] error_total;
    } out_item_t;

endpackage

// ===== hw/rtl/delimited_record_parser_unit.sv =====
// Delimited record parser. Each input transfer carries one text byte or an
// end-of-input mark and yields at most one result transfer: a field byte, an
// end of field, or an end of record with its start line, field count and
// error flags. Quoted fields, doubled quotes, embedded delimiters and line
// breaks are handled; CR outside quotes is dropped. Every item is parsed in
// the cycle it is accepted, so one item per clock is sustained while s_ready
// is high; the result sits in an output register backed by a one-entry skid
// register, and s_ready drops only when both are full.
// Write delimiter (index 0) and has_header (index 1) only while idle; an
// end-of-input item returns all parser state and counters to reset.
module delimited_record_parser_unit
    import drp_pkg::*;
#(
    parameter int MAX_FIELDS = 1024,
    parameter int COUNT_BITS = 32
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  in_item_t                  s_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output out_item_t                 m_data,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_wdata
);

    localparam int FW = $clog2(MAX_FIELDS + 1);
    localparam logic [FW-1:0] FIELD_MAX = FW'(MAX_FIELDS);
    localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

    // Configuration
    logic [7:0] delimiter_reg;
    logic       has_header_reg;

    // Parser state
    logic                  in_quote_reg, in_quote_next;
    logic                  quote_pending_reg, quote_pending_next;
    logic                  content_seen_reg, content_seen_next;
    logic                  record_started_reg, record_started_next;
    logic [COUNT_BITS-1:0] line_count_reg, line_count_next;
    logic [COUNT_BITS-1:0] record_start_line_reg, record_start_line_next;
    logic [FW-1:0]         field_count_reg, field_count_next;
    logic                  width_known_reg, width_known_next;
    logic [FW-1:0]         expected_width_reg, expected_width_next;
    logic                  header_pending_reg, header_pending_next;
    logic [COUNT_BITS-1:0] row_count_reg, row_count_next;
    logic [COUNT_BITS-1:0] error_count_reg, error_count_next;

    // Output register and skid register
    out_item_t head_reg, head_next;
    logic      head_valid_reg, head_valid_next;
    out_item_t skid_reg, skid_next;
    logic      skid_valid_reg, skid_valid_next;

    logic                  accept;
    logic                  pop;
    logic                  res_push;
    out_item_t             res_item;
    logic                  unquoted;
    logic [7:0]            ch;
    logic [COUNT_BITS-1:0] line_inc, row_inc, err_inc;
    logic [FW-1:0]         field_inc;

    // Record finish values
    logic                  fin_unterm;
    logic                  fin_needed;
    logic [COUNT_BITS-1:0] fin_rline;
    logic [FW-1:0]         fin_exp;
    logic                  fin_mism;
    logic [COUNT_BITS-1:0] fin_row, fin_err;
    out_item_t             fin_item;

    assign accept  = s_valid && s_ready;
    assign pop     = head_valid_reg && m_ready;
    assign s_ready = !skid_valid_reg;
    assign m_valid = head_valid_reg;
    assign m_data  = head_reg;
    assign ch      = s_data.char_in;

    // Saturating increments
    assign line_inc  = (line_count_reg == '1) ? line_count_reg : line_count_reg + COUNT_ONE;
    assign row_inc   = (row_count_reg == '1) ? row_count_reg : row_count_reg + COUNT_ONE;
    assign err_inc   = (error_count_reg == '1) ? error_count_reg : error_count_reg + COUNT_ONE;
    assign field_inc = (field_count_reg >= FIELD_MAX) ? FIELD_MAX
                                                      : field_count_reg + FW'(1);

    // Values of a record finished by this item
    always_comb begin
        fin_unterm = (s_data.command == CMD_END) && in_quote_reg && !quote_pending_reg;
        fin_needed = content_seen_reg || (field_count_reg != '0) || fin_unterm;
        fin_rline  = record_started_reg ? record_start_line_reg : line_count_reg;
        fin_exp    = (header_pending_reg || !width_known_reg) ? field_inc
                                                              : expected_width_reg;
        fin_mism   = !header_pending_reg && (field_inc != fin_exp);
        fin_row    = header_pending_reg ? row_count_reg : row_inc;
        fin_err    = (!header_pending_reg && (fin_unterm || fin_mism)) ? err_inc
                                                                       : error_count_reg;
        fin_item                 = '0;
        fin_item.kind            = KIND_RECORD_END;
        fin_item.record_line     = 32'(fin_rline);
        fin_item.record_fields   = 11'(field_inc);
        fin_item.unterminated    = fin_unterm;
        fin_item.width_mismatch  = fin_mism;
        fin_item.header_record   = header_pending_reg;
        fin_item.expected_fields = 11'(fin_exp);
        fin_item.data_rows       = 32'(fin_row);
        fin_item.error_total     = 32'(fin_err);
    end

    // Parser step
    always_comb begin
        in_quote_next          = in_quote_reg;
        quote_pending_next     = quote_pending_reg;
        content_seen_next      = content_seen_reg;
        record_started_next    = record_started_reg;
        line_count_next        = line_count_reg;
        record_start_line_next = record_start_line_reg;
        field_count_next       = field_count_reg;
        width_known_next       = width_known_reg;
        expected_width_next    = expected_width_reg;
        header_pending_next    = header_pending_reg;
        row_count_next         = row_count_reg;
        error_count_next       = error_count_reg;
        res_push               = 1'b0;
        unquoted               = 1'b0;
        res_item                 = '0;
        res_item.kind            = KIND_BYTE;
        res_item.expected_fields = 11'(expected_width_reg);
        res_item.data_rows       = 32'(row_count_reg);
        res_item.error_total     = 32'(error_count_reg);

        if (accept) begin
            if (s_data.command == CMD_END) begin
                if (fin_needed) begin
                    res_push = 1'b1;
                    res_item = fin_item;
                end
                in_quote_next          = 1'b0;
                quote_pending_next     = 1'b0;
                content_seen_next      = 1'b0;
                record_started_next    = 1'b0;
                line_count_next        = COUNT_ONE;
                record_start_line_next = COUNT_ONE;
                field_count_next       = '0;
                width_known_next       = 1'b0;
                expected_width_next    = '0;
                header_pending_next    = has_header_reg;
                row_count_next         = '0;
                error_count_next       = '0;
            end else if (quote_pending_reg) begin
                quote_pending_next = 1'b0;
                if (ch == CH_QUOTE) begin
                    // doubled quote: one literal quote byte
                    res_push          = 1'b1;
                    res_item.char_out = CH_QUOTE;
                end else begin
                    in_quote_next = 1'b0;
                    unquoted      = 1'b1;
                end
            end else if (in_quote_reg) begin
                if (ch == CH_QUOTE) begin
                    quote_pending_next = 1'b1;
                end else begin
                    if (ch == CH_LF) begin
                        line_count_next = line_inc;
                    end
                    res_push          = 1'b1;
                    res_item.char_out = ch;
                end
            end else begin
                unquoted = 1'b1;
            end

            if (unquoted) begin
                if (ch == CH_QUOTE) begin
                    in_quote_next     = 1'b1;
                    content_seen_next = 1'b1;
                    if (!record_started_reg) begin
                        record_start_line_next = line_count_reg;
                        record_started_next    = 1'b1;
                    end
                end else if (ch == delimiter_reg) begin
                    field_count_next  = field_inc;
                    content_seen_next = 1'b1;
                    if (!record_started_reg) begin
                        record_start_line_next = line_count_reg;
                        record_started_next    = 1'b1;
                    end
                    res_push      = 1'b1;
                    res_item.kind = KIND_FIELD_END;
                end else if (ch == CH_CR) begin
                    res_push = 1'b0;
                end else if (ch == CH_LF) begin
                    res_push            = 1'b1;
                    res_item            = fin_item;
                    header_pending_next = 1'b0;
                    expected_width_next = fin_exp;
                    width_known_next    = 1'b1;
                    row_count_next      = fin_row;
                    error_count_next    = fin_err;
                    field_count_next    = '0;
                    content_seen_next   = 1'b0;
                    record_started_next = 1'b0;
                    line_count_next     = line_inc;
                end else begin
                    content_seen_next = 1'b1;
                    if (!record_started_reg) begin
                        record_start_line_next = line_count_reg;
                        record_started_next    = 1'b1;
                    end
                    res_push          = 1'b1;
                    res_item.char_out = ch;
                end
            end
        end

        // has_header write reloads the header flag until a record finishes
        if (cfg_we && (cfg_index == CFG_HAS_HEADER) && !width_known_reg) begin
            header_pending_next = cfg_wdata[0];
        end
    end

    // Output register and skid register
    always_comb begin
        head_next       = head_reg;
        head_valid_next = head_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (!head_valid_reg) begin
            head_next       = res_item;
            head_valid_next = res_push;
        end else if (pop) begin
            if (skid_valid_reg) begin
                head_next       = skid_reg;
                skid_next       = res_item;
                skid_valid_next = res_push;
            end else begin
                head_next       = res_item;
                head_valid_next = res_push;
            end
        end else if (res_push) begin
            skid_next       = res_item;
            skid_valid_next = 1'b1;
        end
    end

    // Control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delimiter_reg         <= DELIMITER_RESET;
            has_header_reg        <= HAS_HEADER_RESET;
            in_quote_reg          <= 1'b0;
            quote_pending_reg     <= 1'b0;
            content_seen_reg      <= 1'b0;
            record_started_reg    <= 1'b0;
            line_count_reg        <= COUNT_ONE;
            record_start_line_reg <= COUNT_ONE;
            field_count_reg       <= '0;
            width_known_reg       <= 1'b0;
            expected_width_reg    <= '0;
            header_pending_reg    <= HAS_HEADER_RESET;
            row_count_reg         <= '0;
            error_count_reg       <= '0;
            head_valid_reg        <= 1'b0;
            skid_valid_reg        <= 1'b0;
        end else begin
            if (cfg_we && (cfg_index == CFG_DELIMITER)) begin
                delimiter_reg <= cfg_wdata[7:0];
            end
            if (cfg_we && (cfg_index == CFG_HAS_HEADER)) begin
                has_header_reg <= cfg_wdata[0];
            end
            in_quote_reg          <= in_quote_next;
            quote_pending_reg     <= quote_pending_next;
            content_seen_reg      <= content_seen_next;
            record_started_reg    <= record_started_next;
            line_count_reg        <= line_count_next;
            record_start_line_reg <= record_start_line_next;
            field_count_reg       <= field_count_next;
            width_known_reg       <= width_known_next;
            expected_width_reg    <= expected_width_next;
            header_pending_reg    <= header_pending_next;
            row_count_reg         <= row_count_next;
            error_count_reg       <= error_count_next;
            head_valid_reg        <= head_valid_next;
            skid_valid_reg        <= skid_valid_next;
        end
    end

    // Result payload registers
    always_ff @(posedge aclk) begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

endmodule

// ===== hw/rtl/drp_port_checker.sv =====
module drp_port_checker
    import drp_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    // A stalled result transfer holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // No result right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Only end-of-record results carry record information
    a_record_only: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.kind != KIND_RECORD_END) |->
            (m_data.record_line == '0) && (m_data.record_fields == '0) &&
            !m_data.unterminated && !m_data.width_mismatch && !m_data.header_record)
        else $error("record fields set on a non-record result");

    // Header records are never flagged as width mismatch; record ends carry no byte
    a_header_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.kind == KIND_RECORD_END) |->
            !(m_data.header_record && m_data.width_mismatch) && (m_data.char_out == '0) &&
            (m_data.record_line != '0))
        else $error("bad end-of-record result");

endmodule

bind delimited_record_parser_unit drp_port_checker u_drp_port_checker (.*);
